// ----- src/bfst_pkg.sv -----
// Shared package for the best-fit free space table.
// Holds field widths, request and status codes, table entry layout and the
// command and status structures between the controller and the datapath.
package bfst_pkg;

	// Default number of table entries
	localparam int TABLE_ENTRIES_DEF = 64;

	// Field widths of a request and of a reply
	localparam int MODE_W   = 3;
	localparam int SIZE_W   = 16;
	localparam int OFFSET_W = 32;
	localparam int STATUS_W = 2;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_INS_HEAD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_TAIL   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_SORTED = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FIND       = 3'd4;
	localparam logic [MODE_W-1:0] MODE_BEST_FIT   = 3'd5;

	// Reply status codes
	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NONE = 2'd2;

	// One table entry as stored in the RAM
	typedef struct packed {
		logic [SIZE_W-1:0]   size;
		logic [OFFSET_W-1:0] offset;
	} slot_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_POS_HEAD,
		DP_POS_TAIL,
		DP_SCAN_START,
		DP_SCAN,
		DP_DOWN_START,
		DP_DOWN,
		DP_UP_START,
		DP_UP
	} dp_op_t;

	// Command bundle from the controller to the datapath
	typedef struct packed {
		dp_op_t              op;
		logic                out_load;
		logic [STATUS_W-1:0] out_status;
		logic                out_found;
	} dp_cmd_t;

	// Status bundle from the datapath to the controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              scan_stop;
		logic              step_done;
		logic              hit;
		logic              out_free;
	} dp_stat_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DOWN_INIT,
		S_DOWN,
		S_UP_INIT,
		S_UP,
		S_REPLY
	} state_t;

endpackage

// ----- src/bfst_req_if.sv -----
// Request channel of the best-fit free space table.
// Carries valid, ready and the request fields; widths come from bfst_pkg.
interface bfst_req_if import bfst_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [SIZE_W-1:0]   record_size;
	logic [OFFSET_W-1:0] record_offset;

	modport source (
		output valid,
		output mode,
		output record_size,
		output record_offset,
		input  ready
	);

	modport sink (
		input  valid,
		input  mode,
		input  record_size,
		input  record_offset,
		output ready
	);

endinterface

// ----- src/bfst_rsp_if.sv -----
// Reply channel of the best-fit free space table.
// Carries valid, ready and the reply fields; widths come from bfst_pkg.
interface bfst_rsp_if import bfst_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [OFFSET_W-1:0] found_offset;
	logic [SIZE_W-1:0]   found_size;

	modport source (
		output valid,
		output status,
		output found_offset,
		output found_size,
		input  ready
	);

	modport sink (
		input  valid,
		input  status,
		input  found_offset,
		input  found_size,
		output ready
	);

endinterface

// ----- src/best_fit_free_space_table.sv -----
// Best-fit free space table: keeps up to TABLE_ENTRIES free slots (size and
// offset) in a single RAM, in the order that the insert modes set, and
// answers one request at a time with one reply. Requests that walk the table
// do so through the RAM's one read port, one entry per cycle. A find or best
// fit scans the table (a find stops at its first match), a sorted insert
// scans up to its position and then shifts the entries behind it, a remove
// scans for the offset and, when it is present, moves the entries behind it
// up a place, a head insert shifts every entry, and a tail insert, an insert
// into a full table or an unused mode walks nothing. The reply load waits
// while the output register still holds a reply that has not been taken. A
// new request is taken in the cycle after the reply is loaded, so requests
// are not overlapped.
// The table needs no clearing pass after reset.
// Depends on bfst_pkg, bfst_req_if, bfst_rsp_if, bfst_ctrl and bfst_dp.
module best_fit_free_space_table import bfst_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bfst_req_if.sink   req,
	bfst_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Controller
	bfst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath with the table RAM and reply register
	bfst_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.req_mode          (req.mode),
		.req_record_size   (req.record_size),
		.req_record_offset (req.record_offset),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_status        (rsp.status),
		.rsp_found_offset  (rsp.found_offset),
		.rsp_found_size    (rsp.found_size)
	);

endmodule

// ----- src/bfst_ram.sv -----
// Generic simple dual-port RAM: one write port and one registered read port.
// Stands alone; width and depth are parameters.
module bfst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/bfst_ctrl.sv -----
// Controller of the best-fit free space table: sequences each request
// through the scan, shift and reply phases that its mode needs. Depends on bfst_pkg.
module bfst_ctrl import bfst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t              state_q, state_d;
	logic [STATUS_W-1:0] reply_status_q, reply_status_d;
	logic                reply_found_q, reply_found_d;

	// State and pending reply registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			reply_status_q <= STAT_OK;
			reply_found_q  <= 1'b0;
		end else begin
			state_q        <= state_d;
			reply_status_q <= reply_status_d;
			reply_found_q  <= reply_found_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d        = state_q;
		reply_status_d = reply_status_q;
		reply_found_d  = reply_found_q;
		cmd            = '0;
		cmd.op         = DP_NOP;
		req_ready      = 1'b0;

		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = DP_LOAD;
					state_d = S_DISPATCH;
				end
			end

			S_DISPATCH: begin
				reply_status_d = STAT_OK;
				reply_found_d  = 1'b0;
				if (stat.mode == MODE_INS_HEAD || stat.mode == MODE_INS_TAIL ||
						stat.mode == MODE_INS_SORTED) begin
					if (stat.full) begin
						reply_status_d = STAT_FULL;
						state_d        = S_REPLY;
					end else if (stat.mode == MODE_INS_HEAD) begin
						cmd.op  = DP_POS_HEAD;
						state_d = S_DOWN_INIT;
					end else if (stat.mode == MODE_INS_TAIL) begin
						cmd.op  = DP_POS_TAIL;
						state_d = S_DOWN_INIT;
					end else begin
						cmd.op  = DP_SCAN_START;
						state_d = S_SCAN;
					end
				end else if (stat.mode == MODE_REMOVE || stat.mode == MODE_FIND ||
						stat.mode == MODE_BEST_FIT) begin
					cmd.op  = DP_SCAN_START;
					state_d = S_SCAN;
				end else begin
					// Unused modes change nothing and reply with success.
					state_d = S_REPLY;
				end
			end

			S_SCAN: begin
				cmd.op = DP_SCAN;
				if (stat.scan_stop) begin
					if (stat.mode == MODE_INS_SORTED) begin
						state_d = S_DOWN_INIT;
					end else if (stat.mode == MODE_REMOVE) begin
						state_d = S_UP_INIT;
					end else begin
						reply_found_d = 1'b1;
						state_d       = S_REPLY;
					end
				end else if (stat.step_done) begin
					if (stat.mode == MODE_INS_SORTED) begin
						// No larger entry: the new one goes at the end.
						state_d = S_DOWN_INIT;
					end else if (stat.mode == MODE_BEST_FIT && stat.hit) begin
						reply_found_d = 1'b1;
						state_d       = S_REPLY;
					end else begin
						reply_status_d = STAT_NONE;
						state_d        = S_REPLY;
					end
				end
			end

			S_DOWN_INIT: begin
				cmd.op  = DP_DOWN_START;
				state_d = S_DOWN;
			end

			S_DOWN: begin
				cmd.op = DP_DOWN;
				if (stat.step_done) begin
					state_d = S_REPLY;
				end
			end

			S_UP_INIT: begin
				cmd.op  = DP_UP_START;
				state_d = S_UP;
			end

			S_UP: begin
				cmd.op = DP_UP;
				if (stat.step_done) begin
					state_d = S_REPLY;
				end
			end

			S_REPLY: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = reply_status_q;
					cmd.out_found  = reply_found_q;
					state_d        = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/bfst_dp.sv -----
// Datapath of the best-fit free space table: table RAM, entry count, walk
// pointer, match logic and the reply register. Depends on bfst_pkg, bfst_ram.
module bfst_dp import bfst_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [MODE_W-1:0]   req_mode,
	input  logic [SIZE_W-1:0]   req_record_size,
	input  logic [OFFSET_W-1:0] req_record_offset,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [STATUS_W-1:0] rsp_status,
	output logic [OFFSET_W-1:0] rsp_found_offset,
	output logic [SIZE_W-1:0]   rsp_found_size
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

	// Request held for the duration of the walk
	logic [MODE_W-1:0]   mode_q;
	logic [SIZE_W-1:0]   size_q;
	logic [OFFSET_W-1:0] offset_q;

	// Walk control
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] pos_q;
	logic [IDX_W-1:0] didx_q;
	logic             dv_q;
	logic             hit_q;
	slot_t            best_q;

	// Reply register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [OFFSET_W-1:0] rsp_offset_q;
	logic [SIZE_W-1:0]   rsp_size_q;

	// RAM ports
	logic             issue;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] didx_d;
	slot_t            rd_data;
	logic             we;
	logic [IDX_W-1:0] wr_addr;
	slot_t            wr_data;

	logic step_done;
	logic match_first;
	logic better;
	logic scan_stop;

	bfst_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Read issue for the walk: forward for scans and upward shifts,
	// backward for the downward shift that opens a gap.
	always_comb begin
		issue   = 1'b0;
		rd_addr = ptr_q[IDX_W-1:0];
		didx_d  = ptr_q[IDX_W-1:0];
		case (cmd.op)
			DP_SCAN: begin
				issue = (ptr_q < count_q);
			end
			DP_DOWN: begin
				issue   = (ptr_q > pos_q);
				rd_addr = IDX_W'(ptr_q - CNT_W'(1));
			end
			DP_UP: begin
				issue  = (ptr_q < count_q);
				didx_d = IDX_W'(ptr_q - CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	assign step_done = !issue && !dv_q;

	// Entry compare against the held request
	always_comb begin
		case (mode_q)
			MODE_INS_SORTED: match_first = (rd_data.size > size_q);
			MODE_REMOVE:     match_first = (rd_data.offset == offset_q);
			MODE_FIND:       match_first = (rd_data.size == size_q);
			default:         match_first = 1'b0;
		endcase
	end

	assign better    = (rd_data.size >= size_q) && (!hit_q || (rd_data.size < best_q.size));
	assign scan_stop = (cmd.op == DP_SCAN) && dv_q && match_first;

	// Table writes: shifted entries while moving, the new entry at the end
	always_comb begin
		we      = 1'b0;
		wr_addr = didx_q;
		wr_data = rd_data;
		if ((cmd.op == DP_DOWN || cmd.op == DP_UP) && dv_q) begin
			we = 1'b1;
		end else if (cmd.op == DP_DOWN && step_done) begin
			we             = 1'b1;
			wr_addr        = pos_q[IDX_W-1:0];
			wr_data.size   = size_q;
			wr_data.offset = offset_q;
		end
	end

	// Control registers of the walk and the reply handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			pos_q       <= '0;
			didx_q      <= '0;
			dv_q        <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				DP_POS_HEAD: begin
					pos_q <= '0;
				end
				DP_POS_TAIL: begin
					pos_q <= count_q;
				end
				DP_SCAN_START: begin
					ptr_q <= '0;
					dv_q  <= 1'b0;
					hit_q <= 1'b0;
					pos_q <= count_q;
				end
				DP_SCAN: begin
					dv_q <= issue;
					if (issue) begin
						ptr_q  <= ptr_q + CNT_W'(1);
						didx_q <= didx_d;
					end
					if (dv_q && mode_q == MODE_BEST_FIT && better) begin
						hit_q <= 1'b1;
					end
					if (scan_stop) begin
						hit_q <= 1'b1;
						pos_q <= CNT_W'(didx_q);
					end
				end
				DP_DOWN_START: begin
					ptr_q <= count_q;
					dv_q  <= 1'b0;
				end
				DP_DOWN: begin
					dv_q <= issue;
					if (issue) begin
						ptr_q  <= ptr_q - CNT_W'(1);
						didx_q <= didx_d;
					end
					if (step_done) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				DP_UP_START: begin
					ptr_q <= pos_q + CNT_W'(1);
					dv_q  <= 1'b0;
				end
				DP_UP: begin
					dv_q <= issue;
					if (issue) begin
						ptr_q  <= ptr_q + CNT_W'(1);
						didx_q <= didx_d;
					end
					if (step_done) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase

			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request, best entry so far and reply fields
	always_ff @(posedge clk) begin
		if (cmd.op == DP_LOAD) begin
			mode_q   <= req_mode;
			size_q   <= req_record_size;
			offset_q <= req_record_offset;
		end
		if (cmd.op == DP_SCAN && dv_q &&
				((mode_q == MODE_BEST_FIT && better) || match_first)) begin
			best_q <= rd_data;
		end
		if (cmd.out_load) begin
			rsp_status_q <= cmd.out_status;
			rsp_offset_q <= cmd.out_found ? best_q.offset : '0;
			rsp_size_q   <= cmd.out_found ? best_q.size : '0;
		end
	end

	// Status back to the controller
	always_comb begin
		stat           = '0;
		stat.mode      = mode_q;
		stat.full      = (count_q == CNT_FULL);
		stat.scan_stop = scan_stop;
		stat.step_done = step_done;
		stat.hit       = hit_q;
		stat.out_free  = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid        = rsp_valid_q;
	assign rsp_status       = rsp_status_q;
	assign rsp_found_offset = rsp_offset_q;
	assign rsp_found_size   = rsp_size_q;

	// The entry count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count beyond table size");

	// The entry count moves by at most one per cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)) ||
		(count_q == $past(count_q) - CNT_W'(1)))
		else $error("entry count jumped");

	// Opening a gap only ever writes above the insert position.
	a_shift_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_DOWN && dv_q) |-> (CNT_W'(didx_q) > pos_q))
		else $error("shift wrote at or below the insert position");

	// An insert never completes into a full table.
	a_no_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_DOWN && step_done) |-> (count_q < CNT_FULL))
		else $error("insert into a full table");

	// A reply is only loaded when the reply register is free.
	a_reply_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("reply overwritten before it was taken");

endmodule

// ----- verif/tb_best_fit_free_space_table.sv -----
// Testbench for best_fit_free_space_table: a directed run, then random requests.
// A scoreboard class keeps its own copy of the table and checks every reply.
// Depends on bfst_pkg, bfst_req_if, bfst_rsp_if and best_fit_free_space_table.
module tb_best_fit_free_space_table import bfst_pkg::*;;

	localparam int TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
	localparam int RANDOM_ITEMS   = 1580;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 100;

	// Modes that the block treats as no-ops.
	localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] offset;
		logic [SIZE_W-1:0]   size;
	} reply_t;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

	// Keeps a shadow copy of the free table and the replies still owed.
	class free_table_scoreboard;
		logic [SIZE_W-1:0]   sizes[TABLE_ENTRIES];
		logic [OFFSET_W-1:0] offsets[TABLE_ENTRIES];
		int                  fill;
		reply_t              owed[$];
		int                  errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		function void report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endfunction

		// Applies an accepted request to the shadow table and queues its reply.
		function void note_request(logic [MODE_W-1:0] m, logic [SIZE_W-1:0] s,
		                           logic [OFFSET_W-1:0] o);
			reply_t r;
			int     pos;
			int     i;
			bit     hit;
			r.status = STAT_OK;
			r.offset = '0;
			r.size   = '0;
			pos = 0;
			hit = 1'b0;
			case (m)
				MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_SORTED: begin
					if (fill >= TABLE_ENTRIES) begin
						r.status = STAT_FULL;
					end else begin
						if (m == MODE_INS_TAIL) begin
							pos = fill;
						end else if (m == MODE_INS_SORTED) begin
							// Equal sizes keep their order: the new entry goes behind them.
							while (pos < fill && sizes[pos] <= s)
								pos++;
						end
						for (i = fill; i > pos; i--) begin
							sizes[i]   = sizes[i-1];
							offsets[i] = offsets[i-1];
						end
						sizes[pos]   = s;
						offsets[pos] = o;
						fill++;
					end
				end
				MODE_REMOVE: begin
					// Only the first entry with this offset goes.
					for (i = 0; i < fill && !hit; i++) begin
						if (offsets[i] == o) begin
							pos = i;
							hit = 1'b1;
						end
					end
					if (hit) begin
						for (i = pos; i + 1 < fill; i++) begin
							sizes[i]   = sizes[i+1];
							offsets[i] = offsets[i+1];
						end
						fill--;
					end else begin
						r.status = STAT_NONE;
					end
				end
				MODE_FIND: begin
					for (i = 0; i < fill && !hit; i++) begin
						if (sizes[i] == s) begin
							r.offset = offsets[i];
							r.size   = sizes[i];
							hit      = 1'b1;
						end
					end
					if (!hit)
						r.status = STAT_NONE;
				end
				MODE_BEST_FIT: begin
					// Strictly smaller only, so the earliest entry wins a tie.
					for (i = 0; i < fill; i++) begin
						if (sizes[i] >= s && (!hit || sizes[i] < r.size)) begin
							r.offset = offsets[i];
							r.size   = sizes[i];
							hit      = 1'b1;
						end
					end
					if (!hit)
						r.status = STAT_NONE;
				end
				default: begin
				end
			endcase
			owed.push_back(r);
		endfunction

		// Compares one accepted reply with the oldest one owed.
		function void check_reply(logic [STATUS_W-1:0] st, logic [OFFSET_W-1:0] fo,
		                          logic [SIZE_W-1:0] fs);
			reply_t r;
			if (owed.size() == 0) begin
				report($sformatf("reply with none owed: status %0d offset %h size %h",
				                 st, fo, fs));
				return;
			end
			r = owed.pop_front();
			if (st !== r.status)
				report($sformatf("status %0d, expected %0d", st, r.status));
			if (fo !== r.offset)
				report($sformatf("found_offset %h, expected %h", fo, r.offset));
			if (fs !== r.size)
				report($sformatf("found_size %h, expected %h", fs, r.size));
		endfunction
	endclass

	bit   clk = 1'b0;
	logic arst_n;
	bit   no_idle = 1'b0;
	int   quiet_cycles = 0;

	free_table_scoreboard sb;

	bfst_req_if req_ch ();
	bfst_rsp_if rsp_ch ();

	best_fit_free_space_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always #1 clk = ~clk;

	// Reply side stalls at random, except during the stretch with no idling.
	always @(negedge clk) begin
		rsp_ch.ready <= no_idle || ($urandom_range(99) >= 30);
	end

	// Watches both channels, feeds the scoreboard and guards against a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.mode, req_ch.record_size, req_ch.record_offset);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_reply(rsp_ch.status, rsp_ch.found_offset, rsp_ch.found_size);
		end
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("best_fit_free_space_table test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Presents one request from a falling edge and returns at the falling edge
	// after it is taken. Valid stays high into the next request unless it idles.
	task automatic send_request(input logic [MODE_W-1:0] m, input logic [SIZE_W-1:0] s,
	                            input logic [OFFSET_W-1:0] o);
		while (!no_idle && $urandom_range(99) < 30) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.mode          <= m;
		req_ch.record_size   <= s;
		req_ch.record_offset <= o;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Sizes lean towards a narrow range so that ties and exact hits are common.
	function automatic logic [SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return SIZE_W'($urandom_range(31));
		if (r < 62)
			return '0;
		if (r < 70)
			return '1;
		return SIZE_W'($urandom);
	endfunction

	// Offsets come often from a small pool so that duplicates occur.
	function automatic logic [OFFSET_W-1:0] pick_offset();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return $urandom_range(31);
		if (r < 55)
			return '0;
		if (r < 60)
			return '1;
		return $urandom;
	endfunction

	// Lookup sizes are mostly taken from the table, sometimes nudged by one.
	function automatic logic [SIZE_W-1:0] lookup_size();
		logic [SIZE_W-1:0] s;
		int                r;
		r = $urandom_range(99);
		if (sb.fill == 0 || r >= 65)
			return pick_size();
		s = sb.sizes[$urandom_range(sb.fill - 1)];
		if (r < 15)
			s = s + 1'b1;
		else if (r < 25)
			s = s - 1'b1;
		return s;
	endfunction

	// Removal keys mostly hit a stored entry.
	function automatic logic [OFFSET_W-1:0] remove_offset();
		if (sb.fill > 0 && $urandom_range(99) < 85)
			return sb.offsets[$urandom_range(sb.fill - 1)];
		return pick_offset();
	endfunction

	// Picks and sends one random request weighted by the phase.
	task automatic random_request(input phase_t ph);
		int                r;
		int                ins_w;
		int                rem_w;
		logic [MODE_W-1:0] m;
		r = $urandom_range(99);
		case (ph)
			PH_FILL:  begin ins_w = 70; rem_w = 8;  end
			PH_DRAIN: begin ins_w = 12; rem_w = 55; end
			default:  begin ins_w = 35; rem_w = 22; end
		endcase
		if (r < ins_w) begin
			case ($urandom_range(2))
				0:       m = MODE_INS_HEAD;
				1:       m = MODE_INS_TAIL;
				default: m = MODE_INS_SORTED;
			endcase
			send_request(m, pick_size(), pick_offset());
		end else if (r < ins_w + rem_w) begin
			send_request(MODE_REMOVE, pick_size(), remove_offset());
		end else if (r < 95) begin
			m = ($urandom_range(1) != 0) ? MODE_FIND : MODE_BEST_FIT;
			send_request(m, lookup_size(), $urandom);
		end else begin
			m = ($urandom_range(1) != 0) ? MODE_UNUSED_B : MODE_UNUSED_A;
			send_request(m, SIZE_W'($urandom), $urandom);
		end
	endtask

	initial begin
		phase_t ph;
		int     n;
		int     extra;
		int     mixed_left;
		sb = new();
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.mode          = MODE_INS_HEAD;
		req_ch.record_size   = '0;
		req_ch.record_offset = '0;
		rsp_ch.ready         = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty table, no-op modes, field extremes, ties and duplicates.
		send_request(MODE_REMOVE, '0, '0);
		send_request(MODE_FIND, 16'd5, '1);
		send_request(MODE_BEST_FIT, '0, '0);
		send_request(MODE_UNUSED_A, '1, '1);
		send_request(MODE_UNUSED_B, 16'h5a5a, 32'ha5a5a5a5);
		send_request(MODE_INS_HEAD, '1, '1);
		send_request(MODE_INS_TAIL, '0, '0);
		send_request(MODE_INS_SORTED, 16'd100, 32'h1000);
		send_request(MODE_INS_SORTED, 16'd100, 32'h2000);
		send_request(MODE_INS_HEAD, 16'd50, 32'h1000);
		send_request(MODE_INS_TAIL, 16'd100, 32'h3000);
		send_request(MODE_FIND, 16'd100, '0);
		send_request(MODE_FIND, 16'd7, '0);
		send_request(MODE_BEST_FIT, 16'd60, '0);
		send_request(MODE_BEST_FIT, '0, '0);
		send_request(MODE_BEST_FIT, '1, '0);
		send_request(MODE_REMOVE, '0, 32'h1000);
		send_request(MODE_REMOVE, '0, 32'h1000);
		send_request(MODE_REMOVE, '0, 32'hdead);
		send_request(MODE_INS_SORTED, '0, 32'h5);
		send_request(MODE_INS_SORTED, '1, 32'h6);
		send_request(MODE_BEST_FIT, 16'd101, '0);

		// Random part: fill to the limit, drain to empty, then a mixed stretch.
		ph         = PH_FILL;
		extra      = 0;
		mixed_left = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			no_idle = (n >= 700 && n < 1000);
			random_request(ph);
			case (ph)
				PH_FILL: begin
					if (sb.fill >= TABLE_ENTRIES)
						extra++;
					if (extra >= 6) begin
						ph    = PH_DRAIN;
						extra = 0;
					end
				end
				PH_DRAIN: begin
					if (sb.fill == 0)
						extra++;
					if (extra >= 4) begin
						ph         = PH_MIXED;
						extra      = 0;
						mixed_left = 60;
					end
				end
				default: begin
					mixed_left--;
					if (mixed_left <= 0)
						ph = PH_FILL;
				end
			endcase
		end
		req_ch.valid <= 1'b0;
		no_idle = 1'b0;

		// Wait for every owed reply, then a while longer for strays.
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("best_fit_free_space_table test passed");
		else
			$display("best_fit_free_space_table test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/bfst_pkg.sv
src/bfst_req_if.sv
src/bfst_rsp_if.sv
src/bfst_ram.sv
src/bfst_ctrl.sv
src/bfst_dp.sv
src/best_fit_free_space_table.sv
verif/tb_best_fit_free_space_table.sv
